[rtl/tcw_pkg.sv]
// Shared constants, widths and operation codes for the text console writer.
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Shared step unit operations
  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_e;

endpackage

[rtl/tcw_step_unit.sv]
// Shared add / subtract-compare unit used by the sequencer steps.
module tcw_step_unit #(
  parameter int W = 12
) (
  input  logic         [W-1:0] a_i,
  input  logic         [W-1:0] b_i,
  input  tcw_pkg::op_e         op_i,
  output logic         [W-1:0] sum_o,
  output logic                 ge_o
);
  import tcw_pkg::*;

  logic [W:0] ext;
  logic [W-1:0] b_sel;
  logic sub;

  // Form a + b, or a - b with the carry as a >= b
  assign sub   = (op_i == OP_SUB);
  assign b_sel = sub ? ~b_i : b_i;
  assign ext   = {1'b0, a_i} + {1'b0, b_sel} + (W+1)'(sub);
  assign sum_o = ext[W-1:0];
  assign ge_o  = ext[W];

endmodule

[rtl/tcw_cell_mem.sv]
// Cell store: one write port, one read port with registered read data.
module tcw_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0]   wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [tcw_pkg::CELL_W-1:0]   rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  // Write one cell
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/text_console_writer_unit.sv]
// Text console writer top level: sequencer, cursor state and result register.
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_ready_o   cmd_i, char_code_i, cell_index_i
//   out       output     out_valid_o / out_ready_i cursor_pos_o, cell_char_o,
//                                                  cell_attr_o, scrolled_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_wdata_i (text attribute)
//
// Put writes the cell (ST_PUT), advances the cursor (ST_ADV) and loads the result; a newline
// skips ST_PUT, and a scroll adds a ST_SCROLL sweep that blanks one row. Read steps ST_DIV,
// one subtract step per logical row of the index (<= ROWS), then ST_RDADDR and ST_RDDATA.
// An out-of-range read or an unused command goes straight to ST_RESULT.
// Clear sweeps the cell memory one cell a cycle; after reset the same sweep runs before in_ready_o rises.
// A finished result waits in the output register; the next item is taken meanwhile.
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tcw_pkg::CMD_W-1:0]   cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]   cell_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcw_pkg::POS_W-1:0]   cursor_pos_o,
  output logic [tcw_pkg::CHAR_W-1:0]  cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]  cell_attr_o,
  output logic                        scrolled_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata_i
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int CW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int UW    = CW + 1;
  localparam int IXW   = ((CW > IDX_W) ? CW : IDX_W) + 1;

  localparam logic [CW-1:0]  LAST_CELL  = CW'(CELLS - 1);
  localparam logic [CW-1:0]  LAST_BASE  = CW'((ROWS - 1) * COLUMNS);
  localparam logic [CW-1:0]  COL_STEP   = CW'(COLUMNS);
  localparam logic [CLW-1:0] LAST_COL   = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]  BOTTOM_ROW = RW'(ROWS - 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_INIT   = 9'b000000010,
    ST_PUT    = 9'b000000100,
    ST_ADV    = 9'b000001000,
    ST_SCROLL = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_RDADDR = 9'b001000000,
    ST_RDDATA = 9'b010000000,
    ST_RESULT = 9'b100000000
  } state_e;

  state_e state_q;

  // Control state
  logic [CW-1:0]     addr_q;
  logic [ATTR_W-1:0] fill_attr_q;
  logic              pend_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CW-1:0]     cursor_q;
  logic [CW-1:0]     lrow_base_q;
  logic [CW-1:0]     cur_base_q;
  logic [CW-1:0]     top_base_q;
  logic [CLW-1:0]    col_q;
  logic [RW-1:0]     row_q;
  logic              nl_q;
  logic [CLW-1:0]    sweep_col_q;
  logic              out_valid_q;

  // Payload registers
  logic [CHAR_W-1:0] char_q;
  logic [CW-1:0]     rem_q;
  logic [CHAR_W-1:0] res_char_q;
  logic [ATTR_W-1:0] res_attr_q;
  logic              res_scr_q;
  logic [POS_W-1:0]  out_cursor_q;
  logic [CHAR_W-1:0] out_char_q;
  logic [ATTR_W-1:0] out_attr_q;
  logic              out_scr_q;

  // Shared unit and memory hookup
  logic [UW-1:0]     u_a;
  logic [UW-1:0]     u_b;
  op_e               u_op;
  logic [UW-1:0]     u_sum;
  logic              u_ge;
  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  logic in_xfer;
  logic idx_ok;
  logic wrap;
  logic scroll_now;
  logic out_load;

  // Advance a physical row base by one row, wrapping at the last row
  function automatic logic [CW-1:0] next_base(input logic [CW-1:0] base);
    logic [CW-1:0] res;
    if (base == LAST_BASE) begin
      res = '0;
    end else begin
      res = CW'(base + COL_STEP);
    end
    return res;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign idx_ok      = (IXW'(cell_index_i) < IXW'(CELLS));
  assign wrap        = nl_q || (col_q == LAST_COL);
  assign scroll_now  = wrap && (row_q == BOTTOM_ROW);
  assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  // Select operands for the shared unit
  always_comb begin
    u_a  = '0;
    u_b  = '0;
    u_op = OP_ADD;
    case (state_q)
      ST_INIT, ST_SCROLL: begin
        u_a = UW'(addr_q);
        u_b = UW'(1);
      end
      ST_PUT: begin
        u_a = UW'(cur_base_q);
        u_b = UW'(col_q);
      end
      ST_ADV: begin
        if (wrap) begin
          u_a = UW'(lrow_base_q);
          u_b = UW'(COL_STEP);
        end else begin
          u_a = UW'(cursor_q);
          u_b = UW'(1);
        end
      end
      ST_DIV: begin
        u_a  = UW'(rem_q);
        u_b  = UW'(COL_STEP);
        u_op = OP_SUB;
      end
      ST_RDADDR: begin
        u_a = UW'(addr_q);
        u_b = UW'(rem_q);
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  tcw_step_unit #(
    .W (UW)
  ) u_step (
    .a_i   (u_a),
    .b_i   (u_b),
    .op_i  (u_op),
    .sum_o (u_sum),
    .ge_o  (u_ge)
  );

  // Drive the cell memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = {attr_q, SPACE_CODE};
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {fill_attr_q, SPACE_CODE};
      end
      ST_SCROLL: begin
        mem_we = 1'b1;
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = u_sum[CW-1:0];
        mem_wdata = {attr_q, char_q};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (CW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (u_sum[CW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Sequencer and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      addr_q      <= '0;
      fill_attr_q <= ATTR_RESET;
      pend_q      <= 1'b0;
      attr_q      <= ATTR_RESET;
      cursor_q    <= '0;
      lrow_base_q <= '0;
      cur_base_q  <= '0;
      top_base_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      nl_q        <= 1'b0;
      sweep_col_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_wdata_i;
      end
      // Raise the result valid on a load, drop it once its transfer completes
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          addr_q <= u_sum[CW-1:0];
          if (addr_q == LAST_CELL) begin
            state_q <= pend_q ? ST_RESULT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            case (cmd_i)
              CMD_PUT: begin
                nl_q    <= (char_code_i == NEWLINE_CODE);
                state_q <= (char_code_i == NEWLINE_CODE) ? ST_ADV : ST_PUT;
              end
              CMD_CLEAR: begin
                addr_q      <= '0;
                fill_attr_q <= attr_q;
                pend_q      <= 1'b1;
                cursor_q    <= '0;
                lrow_base_q <= '0;
                cur_base_q  <= '0;
                top_base_q  <= '0;
                col_q       <= '0;
                row_q       <= '0;
                state_q     <= ST_INIT;
              end
              CMD_READ: begin
                addr_q  <= top_base_q;
                state_q <= idx_ok ? ST_DIV : ST_RESULT;
              end
              default: begin
                state_q <= ST_RESULT;
              end
            endcase
          end
        end
        ST_PUT: begin
          state_q <= ST_ADV;
        end
        ST_ADV: begin
          if (scroll_now) begin
            // old top row becomes the blank bottom row
            cursor_q    <= LAST_BASE;
            lrow_base_q <= LAST_BASE;
            col_q       <= '0;
            cur_base_q  <= top_base_q;
            top_base_q  <= next_base(top_base_q);
            addr_q      <= top_base_q;
            sweep_col_q <= '0;
            state_q     <= ST_SCROLL;
          end else if (wrap) begin
            cursor_q    <= u_sum[CW-1:0];
            lrow_base_q <= u_sum[CW-1:0];
            col_q       <= '0;
            row_q       <= row_q + RW'(1);
            cur_base_q  <= next_base(cur_base_q);
            state_q     <= ST_RESULT;
          end else begin
            cursor_q <= u_sum[CW-1:0];
            col_q    <= col_q + CLW'(1);
            state_q  <= ST_RESULT;
          end
        end
        ST_SCROLL: begin
          addr_q      <= u_sum[CW-1:0];
          sweep_col_q <= sweep_col_q + CLW'(1);
          if (sweep_col_q == LAST_COL) begin
            state_q <= ST_RESULT;
          end
        end
        ST_DIV: begin
          // step the physical row base once per logical row
          if (u_ge) begin
            addr_q <= next_base(addr_q);
          end else begin
            state_q <= ST_RDADDR;
          end
        end
        ST_RDADDR: begin
          state_q <= ST_RDDATA;
        end
        ST_RDDATA: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            pend_q  <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the item fields, collect the result, load the output register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q     <= char_code_i;
      rem_q      <= CW'(cell_index_i);
      res_char_q <= '0;
      res_attr_q <= '0;
      res_scr_q  <= 1'b0;
    end
    if ((state_q == ST_ADV) && scroll_now) begin
      res_scr_q <= 1'b1;
    end
    if ((state_q == ST_DIV) && u_ge) begin
      rem_q <= u_sum[CW-1:0];
    end
    if (state_q == ST_RDDATA) begin
      res_char_q <= mem_rdata[CHAR_W-1:0];
      res_attr_q <= mem_rdata[CELL_W-1:CHAR_W];
    end
    if (out_load) begin
      out_cursor_q <= POS_W'(cursor_q);
      out_char_q   <= res_char_q;
      out_attr_q   <= res_attr_q;
      out_scr_q    <= res_scr_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_cursor_q;
  assign cell_char_o  = out_char_q;
  assign cell_attr_o  = out_attr_q;
  assign scrolled_o   = out_scr_q;

  // A scroll always leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_pos_o == POS_W'(LAST_BASE))
    else $error("scroll result with cursor off the bottom row start");

  // Linear cursor tracks row base plus column
  a_cursor_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q == CW'(lrow_base_q + CW'(col_q)))
    else $error("cursor out of step with row base and column");

  // Column and row bases stay on the screen
  a_bases_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LAST_COL && cur_base_q <= LAST_BASE && top_base_q <= LAST_BASE)
    else $error("cursor column or row base out of range");

  // An accepted item always leaves the sequencer busy in the cycle after its transfer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer ready right after a transfer");

endmodule
